// ===== hw/rtl/mfd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the motor feedback frame decoder.
// No dependencies; used by every module of the block by scoped names.
package mfd_pkg;

  localparam int unsigned IdW       = 11;
  localparam int unsigned WordW     = 16;
  localparam int unsigned ChW       = 3;
  localparam int unsigned PosW      = 30;
  localparam int unsigned NumCh     = 5;
  localparam int unsigned NumSlot   = 3;
  localparam int unsigned CfgAddrW  = 3;
  localparam int unsigned QueueDepth = 2;

  localparam int unsigned InDataW  = 64;
  localparam int unsigned OutDataW = 120;

  // Channel codes
  localparam logic [ChW-1:0] ChGimbal  = 3'd0;
  localparam logic [ChW-1:0] ChFront   = 3'd1;
  localparam logic [ChW-1:0] ChBack    = 3'd2;
  localparam logic [ChW-1:0] ChPitch   = 3'd3;
  localparam logic [ChW-1:0] ChFeeder  = 3'd4;

  // Turn tracking slots
  localparam logic [1:0] SlotFront  = 2'd0;
  localparam logic [1:0] SlotBack   = 2'd1;
  localparam logic [1:0] SlotFeeder = 2'd2;

  // Configuration register indexes
  localparam logic [CfgAddrW-1:0] RegChassisThr = 3'd0;
  localparam logic [CfgAddrW-1:0] RegFeederThr  = 3'd1;
  localparam logic [CfgAddrW-1:0] RegCountsTurn = 3'd2;
  localparam logic [CfgAddrW-1:0] RegGimbalId   = 3'd3;
  localparam logic [CfgAddrW-1:0] RegFrontId    = 3'd4;
  localparam logic [CfgAddrW-1:0] RegBackId     = 3'd5;
  localparam logic [CfgAddrW-1:0] RegPitchId    = 3'd6;
  localparam logic [CfgAddrW-1:0] RegFeederId   = 3'd7;

  // Configuration reset values
  localparam logic [WordW-1:0] ChassisThrRst = 16'd4096;
  localparam logic [WordW-1:0] FeederThrRst  = 16'd4000;
  localparam logic [WordW-1:0] CountsTurnRst = 16'd8191;
  localparam logic [IdW-1:0]   GimbalIdRst   = 11'h188;
  localparam logic [IdW-1:0]   FrontIdRst    = 11'h201;
  localparam logic [IdW-1:0]   BackIdRst     = 11'h202;
  localparam logic [IdW-1:0]   PitchIdRst    = 11'h206;
  localparam logic [IdW-1:0]   FeederIdRst   = 11'h207;

  typedef struct packed {
    logic [WordW-1:0] chassis_thr;
    logic [WordW-1:0] feeder_thr;
    logic [WordW-1:0] counts_turn;
    logic [IdW-1:0]   gimbal_id;
    logic [IdW-1:0]   front_id;
    logic [IdW-1:0]   back_id;
    logic [IdW-1:0]   pitch_id;
    logic [IdW-1:0]   feeder_id;
  } cfg_t;

  // Classified frame as held in the queue
  typedef struct packed {
    logic [ChW-1:0]   channel;
    logic [WordW-1:0] word_a;
    logic [WordW-1:0] word_b;
    logic [WordW-1:0] word_c;
  } item_t;

  // Result after the state update, before the position multiply
  typedef struct packed {
    logic [ChW-1:0]          channel;
    logic [WordW-1:0]        first_value;
    logic signed [WordW-1:0] second_value;
    logic signed [WordW-1:0] third_value;
    logic signed [WordW-1:0] turns;
    logic [WordW-1:0]        frames_seen;
  } upd_t;

endpackage

// ===== hw/rtl/motor_feedback_frame_decoder.sv =====
`timescale 1ns / 1ps
// Top level of the motor feedback frame decoder: configuration registers
// and the front end, queue and back end. Uses mfd_pkg.
//
// Input stream: one beat per received bus frame (identifier and three
// big-endian data words). Frames whose identifier matches none of the
// five configured identifiers are dropped without a result.
// Output stream: one beat per matching frame with channel, pass-through
// words, updated turn count, multi-turn position and frame count.
// Configuration: cfg_we_i writes cfg_wdata_i to register cfg_addr_i on the
// clock edge; write only while no frame is in flight.
// Path: a matching frame passes through the queue, the state update register
// and the position multiply into the output register.
// Throughput: one frame per cycle while the output is not stalled; the state update
// of one frame is done before the next frame of the same channel reaches it.
// Stall: when the receiver holds m_axis_tready low the output register,
// the update stage and then the QueueDepth-entry queue fill, after which
// s_axis_tready drops. No beat is lost or repeated.
// Reset: all counters, last angles and turn counts clear to zero and the
// configuration returns to its default identifiers, thresholds and counts per turn.
module motor_feedback_frame_decoder #(
  parameter int unsigned QueueDepth = mfd_pkg::QueueDepth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [mfd_pkg::InDataW-1:0]  s_axis_tdata,  // frame_id, word_a, word_b, word_c
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  output logic [mfd_pkg::OutDataW-1:0] m_axis_tdata,  // channel, first_value, second_value,
                                                      // third_value, turns, position,
                                                      // frames_seen
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  input  logic                         cfg_we_i,
  input  logic [mfd_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [mfd_pkg::WordW-1:0]    cfg_wdata_i
);

  mfd_pkg::cfg_t  cfg_q;
  mfd_pkg::item_t push_item, pop_item;
  logic           push, pop, full, empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.chassis_thr <= mfd_pkg::ChassisThrRst;
      cfg_q.feeder_thr  <= mfd_pkg::FeederThrRst;
      cfg_q.counts_turn <= mfd_pkg::CountsTurnRst;
      cfg_q.gimbal_id   <= mfd_pkg::GimbalIdRst;
      cfg_q.front_id    <= mfd_pkg::FrontIdRst;
      cfg_q.back_id     <= mfd_pkg::BackIdRst;
      cfg_q.pitch_id    <= mfd_pkg::PitchIdRst;
      cfg_q.feeder_id   <= mfd_pkg::FeederIdRst;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        mfd_pkg::RegChassisThr: cfg_q.chassis_thr <= cfg_wdata_i;
        mfd_pkg::RegFeederThr:  cfg_q.feeder_thr  <= cfg_wdata_i;
        mfd_pkg::RegCountsTurn: cfg_q.counts_turn <= cfg_wdata_i;
        mfd_pkg::RegGimbalId:   cfg_q.gimbal_id   <= cfg_wdata_i[mfd_pkg::IdW-1:0];
        mfd_pkg::RegFrontId:    cfg_q.front_id    <= cfg_wdata_i[mfd_pkg::IdW-1:0];
        mfd_pkg::RegBackId:     cfg_q.back_id     <= cfg_wdata_i[mfd_pkg::IdW-1:0];
        mfd_pkg::RegPitchId:    cfg_q.pitch_id    <= cfg_wdata_i[mfd_pkg::IdW-1:0];
        mfd_pkg::RegFeederId:   cfg_q.feeder_id   <= cfg_wdata_i[mfd_pkg::IdW-1:0];
        default: ;
      endcase
    end
  end

  mfd_front u_front (
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .cfg_i         (cfg_q),
    .full_i        (full),
    .push_o        (push),
    .item_o        (push_item)
  );

  mfd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .item_o  (pop_item),
    .empty_o (empty)
  );

  mfd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .empty_i       (empty),
    .item_i        (pop_item),
    .pop_o         (pop),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

endmodule

// ===== hw/rtl/mfd_front.sv =====
`timescale 1ns / 1ps
// Front end: takes input beats, matches the identifier against the
// configured ones and pushes matching frames into the queue. Uses mfd_pkg.
module mfd_front (
  input  logic [mfd_pkg::InDataW-1:0] s_axis_tdata, // frame_id, word_a, word_b, word_c
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  mfd_pkg::cfg_t               cfg_i,
  input  logic                        full_i,
  output logic                        push_o,
  output mfd_pkg::item_t              item_o
);

  logic [mfd_pkg::IdW-1:0] frame_id;
  logic                    match;
  logic [mfd_pkg::ChW-1:0] channel;

  assign frame_id = s_axis_tdata[10:0];

  // Lowest channel number wins when identifiers coincide
  always_comb begin
    match   = 1'b1;
    channel = mfd_pkg::ChGimbal;
    priority if (frame_id == cfg_i.gimbal_id) begin
      channel = mfd_pkg::ChGimbal;
    end else if (frame_id == cfg_i.front_id) begin
      channel = mfd_pkg::ChFront;
    end else if (frame_id == cfg_i.back_id) begin
      channel = mfd_pkg::ChBack;
    end else if (frame_id == cfg_i.pitch_id) begin
      channel = mfd_pkg::ChPitch;
    end else if (frame_id == cfg_i.feeder_id) begin
      channel = mfd_pkg::ChFeeder;
    end else begin
      match = 1'b0;
    end
  end

  assign s_axis_tready  = ~full_i;
  assign push_o         = s_axis_tvalid & ~full_i & match;
  assign item_o.channel = channel;
  assign item_o.word_a  = s_axis_tdata[26:11];
  assign item_o.word_b  = s_axis_tdata[42:27];
  assign item_o.word_c  = s_axis_tdata[58:43];

endmodule

// ===== hw/rtl/mfd_queue.sv =====
`timescale 1ns / 1ps
// Short FIFO of classified frames between front and back end.
// Uses mfd_pkg for the entry type.
module mfd_queue #(
  parameter int unsigned Depth = mfd_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mfd_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output mfd_pkg::item_t item_o,
  output logic           empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  mfd_pkg::item_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== hw/rtl/mfd_back.sv =====
`timescale 1ns / 1ps
// Back end: per-channel frame counters, angle unwrap with saturating turn
// count, then the position multiply into the output register. Uses mfd_pkg.
module mfd_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mfd_pkg::cfg_t                cfg_i,
  input  logic                         empty_i,
  input  mfd_pkg::item_t               item_i,
  output logic                         pop_o,
  output logic [mfd_pkg::OutDataW-1:0] m_axis_tdata, // channel, first_value, second_value,
                                                     // third_value, turns, position, frames_seen
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready
);

  localparam int unsigned WordW = mfd_pkg::WordW;
  localparam logic signed [WordW-1:0] TurnOne = {{(WordW-1){1'b0}}, 1'b1};

  logic [WordW-1:0]        frame_cnt_q [mfd_pkg::NumCh];
  logic [WordW-1:0]        last_angle_q [mfd_pkg::NumSlot];
  logic signed [WordW-1:0] turn_q [mfd_pkg::NumSlot];

  mfd_pkg::upd_t upd_q, upd_d;
  logic          upd_valid_q;
  logic          out_valid_q;
  logic [mfd_pkg::OutDataW-1:0] out_data_q, out_data_d;

  logic          out_ready, upd_ready;
  logic          tracked;
  logic [1:0]    slot;
  logic [WordW-1:0]        thr;
  logic signed [WordW:0]   diff;
  logic signed [WordW+1:0] diff_plus_thr;
  logic signed [WordW-1:0] turn_cur, turn_new;
  logic [WordW-1:0]        frames_new;

  assign out_ready = ~out_valid_q | m_axis_tready;
  assign upd_ready = ~upd_valid_q | out_ready;
  assign pop_o     = ~empty_i & upd_ready;

  always_comb begin
    tracked = 1'b1;
    slot    = mfd_pkg::SlotFront;
    unique case (item_i.channel)
      mfd_pkg::ChFront:  slot = mfd_pkg::SlotFront;
      mfd_pkg::ChBack:   slot = mfd_pkg::SlotBack;
      mfd_pkg::ChFeeder: slot = mfd_pkg::SlotFeeder;
      default:           tracked = 1'b0;
    endcase
  end

  assign thr      = (item_i.channel == mfd_pkg::ChFeeder) ? cfg_i.feeder_thr
                                                          : cfg_i.chassis_thr;
  assign turn_cur = turn_q[slot];
  assign diff     = $signed({1'b0, item_i.word_a}) - $signed({1'b0, last_angle_q[slot]});
  assign diff_plus_thr = $signed({diff[WordW], diff}) + $signed({2'b00, thr});

  // diff > thr decrements, diff < -thr increments, both saturating
  always_comb begin
    turn_new = turn_cur;
    if ($signed(diff) > $signed({1'b0, thr})) begin
      if (turn_cur != {1'b1, {(WordW-1){1'b0}}}) begin
        turn_new = turn_cur - TurnOne;
      end
    end else if (diff_plus_thr[WordW+1]) begin
      if (turn_cur != {1'b0, {(WordW-1){1'b1}}}) begin
        turn_new = turn_cur + TurnOne;
      end
    end
  end

  assign frames_new = frame_cnt_q[item_i.channel] + 1'b1;

  always_comb begin
    upd_d.channel      = item_i.channel;
    upd_d.first_value  = item_i.word_a;
    upd_d.second_value = item_i.word_b;
    upd_d.third_value  = ((item_i.channel == mfd_pkg::ChGimbal) ||
                          (item_i.channel == mfd_pkg::ChPitch)) ? item_i.word_c : '0;
    upd_d.turns        = tracked ? turn_new : '0;
    upd_d.frames_seen  = frames_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(mfd_pkg::NumCh); i++) begin
        frame_cnt_q[i] <= '0;
      end
      for (int i = 0; i < int'(mfd_pkg::NumSlot); i++) begin
        last_angle_q[i] <= '0;
        turn_q[i]       <= '0;
      end
    end else if (pop_o) begin
      frame_cnt_q[item_i.channel] <= frames_new;
      if (tracked) begin
        last_angle_q[slot] <= item_i.word_a;
        turn_q[slot]       <= turn_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upd_valid_q <= 1'b0;
    end else if (upd_ready) begin
      upd_valid_q <= pop_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      upd_q <= upd_d;
    end
  end

  // Position stage: turns is zero for pitch, so angle + cpt * turns covers it
  logic signed [2*WordW:0]       prod;
  logic [mfd_pkg::PosW-1:0]      pos;

  assign prod = $signed({1'b0, cfg_i.counts_turn}) * upd_q.turns;

  always_comb begin
    if (upd_q.channel == mfd_pkg::ChGimbal) begin
      pos = '0;
    end else begin
      pos = prod[mfd_pkg::PosW-1:0] + {{(mfd_pkg::PosW-WordW){1'b0}}, upd_q.first_value};
    end
    out_data_d = {7'd0, upd_q.frames_seen, pos, upd_q.turns, upd_q.third_value,
                  upd_q.second_value, upd_q.first_value, upd_q.channel};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= upd_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && upd_valid_q) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== dv/tb_motor_feedback_frame_decoder.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of motor_feedback_frame_decoder: predicts each feedback beat
// from the frames it feeds in and compares every output field. Needs mfd_pkg and the RTL.
module tb_motor_feedback_frame_decoder;
  import mfd_pkg::*;

  typedef struct packed {
    logic [ChW-1:0]          channel;
    logic [WordW-1:0]        first_value;
    logic signed [WordW-1:0] second_value;
    logic signed [WordW-1:0] third_value;
    logic signed [WordW-1:0] turns;
    logic signed [PosW-1:0]  position;
    logic [WordW-1:0]        frames_seen;
  } feedback_t;

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic [InDataW-1:0]  s_axis_tdata  = '0;  // frame_id, word_a, word_b, word_c
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;  // channel, first_value, second_value, third_value,
                                      // turns, position, frames_seen
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i    = '0;
  logic [WordW-1:0]    cfg_wdata_i   = '0;

  motor_feedback_frame_decoder uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Shadow of the configuration registers
  logic [WordW-1:0] thr_chassis    = ChassisThrRst;
  logic [WordW-1:0] thr_feeder     = FeederThrRst;
  logic [WordW-1:0] counts_per_rev = CountsTurnRst;
  logic [IdW-1:0]   id_of_ch [NumCh];

  // Predicted decoder state
  logic [WordW-1:0] last_angle [NumSlot];
  int               turn_cnt   [NumSlot];
  logic [WordW-1:0] frame_cnt  [NumCh];

  logic [InDataW-1:0] pending_frames [$];
  feedback_t          expected_feedback [$];
  logic [WordW-1:0]   gen_angle [NumCh];

  int        mismatches   = 0;
  int        send_gap     = 0;
  int        take_gap     = 0;
  int        rx_hold      = 0;
  bit        burst_mode   = 1'b0;
  bit        frame_taken  = 1'b0;
  bit        result_taken = 1'b0;
  feedback_t got, want;

  initial begin
    id_of_ch[ChGimbal] = GimbalIdRst;
    id_of_ch[ChFront]  = FrontIdRst;
    id_of_ch[ChBack]   = BackIdRst;
    id_of_ch[ChPitch]  = PitchIdRst;
    id_of_ch[ChFeeder] = FeederIdRst;
    for (int k = 0; k < NumSlot; k++) begin
      last_angle[k] = '0;
      turn_cnt[k]   = 0;
    end
    for (int k = 0; k < NumCh; k++) begin
      frame_cnt[k] = '0;
      gen_angle[k] = '0;
    end
  end

  task automatic decode_frame(input logic [InDataW-1:0] beat);
    logic [IdW-1:0]   id;
    logic [WordW-1:0] wa, wb, wc;
    logic [ChW-1:0]   ch;
    logic [1:0]       slot;
    int               thr, diff, t;
    longint           pos;
    feedback_t        fb;
    id = beat[10:0];
    wa = beat[26:11];
    wb = beat[42:27];
    wc = beat[58:43];
    // lowest channel wins when identifiers coincide
    if (id == id_of_ch[ChGimbal]) ch = ChGimbal;
    else if (id == id_of_ch[ChFront]) ch = ChFront;
    else if (id == id_of_ch[ChBack]) ch = ChBack;
    else if (id == id_of_ch[ChPitch]) ch = ChPitch;
    else if (id == id_of_ch[ChFeeder]) ch = ChFeeder;
    else return;
    frame_cnt[ch]   = frame_cnt[ch] + 16'd1;
    fb.channel      = ch;
    fb.first_value  = wa;
    fb.second_value = wb;
    fb.third_value  = '0;
    fb.turns        = '0;
    fb.position     = '0;
    fb.frames_seen  = frame_cnt[ch];
    if (ch == ChGimbal) begin
      fb.third_value = wc;
    end else if (ch == ChPitch) begin
      fb.third_value = wc;
      fb.position    = 30'(wa);
    end else begin
      slot = (ch == ChFront) ? SlotFront : (ch == ChBack) ? SlotBack : SlotFeeder;
      thr  = (ch == ChFeeder) ? int'(thr_feeder) : int'(thr_chassis);
      diff = int'(wa) - int'(last_angle[slot]);
      t    = turn_cnt[slot];
      if (diff > thr) begin
        if (t > -32768) t--;
      end else if (diff < -thr) begin
        if (t < 32767) t++;
      end
      turn_cnt[slot]   = t;
      last_angle[slot] = wa;
      pos = longint'(wa) + longint'(counts_per_rev) * longint'(t);
      fb.turns    = t[15:0];
      fb.position = pos[29:0];
    end
    expected_feedback.push_back(fb);
  endtask

  task automatic compare_field(input string name, input logic [31:0] expv,
                               input logic [31:0] actv);
    if (expv !== actv) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, expv, actv);
      mismatches++;
    end
  endtask

  // Frame driver
  always @(negedge clk_i) begin
    if (rst_ni && !(s_axis_tvalid && !frame_taken)) begin
      if (frame_taken) begin
        frame_taken = 1'b0;
        send_gap    = burst_mode ? 0 : $urandom_range(0, 9);
      end
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_frames.size() > 0) begin
        s_axis_tdata  <= pending_frames.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      decode_frame(s_axis_tdata);
      frame_taken = 1'b1;
    end
  end

  // Feedback receiver; rx_hold forces a long back-pressure stretch
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (result_taken) begin
        result_taken = 1'b0;
        take_gap     = burst_mode ? 0 : $urandom_range(0, 9);
      end
      if (rx_hold > 0) begin
        rx_hold--;
        m_axis_tready <= 1'b0;
      end else if (take_gap > 0) begin
        take_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      result_taken     = 1'b1;
      got.channel      = m_axis_tdata[2:0];
      got.first_value  = m_axis_tdata[18:3];
      got.second_value = m_axis_tdata[34:19];
      got.third_value  = m_axis_tdata[50:35];
      got.turns        = m_axis_tdata[66:51];
      got.position     = m_axis_tdata[96:67];
      got.frames_seen  = m_axis_tdata[112:97];
      if (expected_feedback.size() == 0) begin
        $error("feedback beat with nothing expected, channel %0d", got.channel);
        mismatches++;
      end else begin
        want = expected_feedback.pop_front();
        compare_field("channel", want.channel, got.channel);
        compare_field("first_value", want.first_value, got.first_value);
        compare_field("second_value", want.second_value, got.second_value);
        compare_field("third_value", want.third_value, got.third_value);
        compare_field("turns", want.turns, got.turns);
        compare_field("position", want.position, got.position);
        compare_field("frames_seen", want.frames_seen, got.frames_seen);
      end
    end
  end

  task automatic queue_frame(input logic [IdW-1:0] id, input logic [WordW-1:0] wa,
                             input logic [WordW-1:0] wb, input logic [WordW-1:0] wc);
    pending_frames.push_back({5'b0, wc, wb, wa, id});
  endtask

  task automatic write_reg(input logic [CfgAddrW-1:0] idx, input logic [WordW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    case (idx)
      RegChassisThr: thr_chassis = val;
      RegFeederThr:  thr_feeder = val;
      RegCountsTurn: counts_per_rev = val;
      RegGimbalId:   id_of_ch[ChGimbal] = val[IdW-1:0];
      RegFrontId:    id_of_ch[ChFront] = val[IdW-1:0];
      RegBackId:     id_of_ch[ChBack] = val[IdW-1:0];
      RegPitchId:    id_of_ch[ChPitch] = val[IdW-1:0];
      RegFeederId:   id_of_ch[ChFeeder] = val[IdW-1:0];
      default: ;
    endcase
  endtask

  // Identifier values are 16 bits so that the dropped upper bits get exercised
  task automatic configure(input logic [15:0] thr_c, input logic [15:0] thr_f,
                           input logic [15:0] cpt, input logic [15:0] gim,
                           input logic [15:0] front, input logic [15:0] back,
                           input logic [15:0] pitch, input logic [15:0] feeder);
    write_reg(RegChassisThr, thr_c);
    write_reg(RegFeederThr, thr_f);
    write_reg(RegCountsTurn, cpt);
    write_reg(RegGimbalId, gim);
    write_reg(RegFrontId, front);
    write_reg(RegBackId, back);
    write_reg(RegPitchId, pitch);
    write_reg(RegFeederId, feeder);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_config();
    logic [15:0] thr_c, thr_f, cpt;
    logic [15:0] ids [NumCh];
    case ($urandom_range(0, 4))
      0:       thr_c = 16'h0000;
      1:       thr_c = 16'hFFFF;
      default: thr_c = 16'($urandom_range(0, 12000));
    endcase
    case ($urandom_range(0, 4))
      0:       thr_f = 16'h0000;
      1:       thr_f = 16'hFFFF;
      default: thr_f = 16'($urandom_range(0, 12000));
    endcase
    case ($urandom_range(0, 3))
      0:       cpt = 16'd1;
      1:       cpt = 16'hFFFF;
      2:       cpt = CountsTurnRst;
      default: cpt = 16'($urandom_range(1, 65535));
    endcase
    for (int k = 0; k < NumCh; k++) ids[k] = 16'($urandom);
    if ($urandom_range(0, 2) == 0) ids[$urandom_range(1, 4)] = ids[$urandom_range(0, 3)];
    configure(thr_c, thr_f, cpt, ids[0], ids[1], ids[2], ids[3], ids[4]);
  endtask

  // Mostly frames for configured channels, with angles near the last one so that
  // the wrap thresholds get hit from both sides
  task automatic queue_random_frame();
    int               ch;
    logic [IdW-1:0]   id;
    logic [WordW-1:0] wa;
    ch = $urandom_range(0, NumCh - 1);
    id = ($urandom_range(0, 99) < 85) ? id_of_ch[ch] : 11'($urandom);
    case ($urandom_range(0, 9))
      0, 1, 2: wa = gen_angle[ch] + 16'($urandom_range(0, 1023)) - 16'd512;
      3, 4, 5: wa = gen_angle[ch] + 16'($urandom_range(0, 24575)) - 16'd12288;
      6: begin
        case ($urandom_range(0, 3))
          0:       wa = 16'h0000;
          1:       wa = 16'hFFFF;
          2:       wa = 16'h7FFF;
          default: wa = 16'h8000;
        endcase
      end
      default: wa = 16'($urandom);
    endcase
    gen_angle[ch] = wa;
    queue_frame(id, wa, 16'($urandom), 16'($urandom));
  endtask

  // Wait until the block is idle; dropped frames may still be in flight
  task automatic drain();
    while (pending_frames.size() != 0 || s_axis_tvalid || expected_feedback.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Default setting: first frame after reset, threshold boundaries, pass-through
    queue_frame(FrontIdRst, 16'hFFFF, 16'h8000, 16'h7FFF);
    queue_frame(FrontIdRst, 16'hEFFF, 16'h0001, 16'h0000);
    queue_frame(FrontIdRst, 16'hDFFE, 16'h7FFF, 16'hFFFF);
    queue_frame(BackIdRst, 16'h1000, 16'hFFFF, 16'h8000);
    queue_frame(BackIdRst, 16'h2001, 16'h0000, 16'h1234);
    queue_frame(FeederIdRst, 16'h0FA1, 16'h8000, 16'h0000);
    queue_frame(FeederIdRst, 16'h0000, 16'h7FFF, 16'hFFFF);
    queue_frame(GimbalIdRst, 16'hFFFF, 16'hFFFF, 16'h8000);
    queue_frame(GimbalIdRst, 16'h0000, 16'h7FFF, 16'h7FFF);
    queue_frame(PitchIdRst, 16'hFFFF, 16'h0000, 16'h8000);
    queue_frame(PitchIdRst, 16'h0000, 16'h8000, 16'hFFFF);
    queue_frame(11'h000, 16'h1111, 16'h2222, 16'h3333);
    queue_frame(11'h7FF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_frame(11'h189, 16'h0000, 16'h0000, 16'h0000);
    drain();

    // All identifiers alike at the top and bottom codes
    configure(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hF7FF, 16'h07FF,
              16'h0000, 16'hF800);
    queue_frame(11'h7FF, 16'hABCD, 16'h8001, 16'h7FFE);
    queue_frame(11'h000, 16'h5555, 16'hAAAA, 16'hC000);
    queue_frame(11'h123, 16'h0000, 16'h0000, 16'h0000);
    drain();

    // Front shadows back; threshold extremes; unit counts per turn
    configure(16'hFFFF, 16'h0000, 16'd1, 16'h0100, 16'h07FF, 16'h07FF, 16'h0000, 16'h0001);
    queue_frame(11'h7FF, 16'h0000, 16'h0000, 16'h0000);
    queue_frame(11'h7FF, 16'hFFFF, 16'h0000, 16'h0000);
    queue_frame(11'h000, 16'h8000, 16'h1234, 16'h4321);
    queue_frame(11'h001, 16'h0005, 16'h0000, 16'h0000);
    queue_frame(11'h001, 16'h0005, 16'h0000, 16'h0000);
    queue_frame(11'h001, 16'h0004, 16'h0000, 16'h0000);
    drain();

    // Back shadows pitch
    configure(16'h8000, 16'd1, 16'd8191, 16'h0010, 16'h0020, 16'h0030, 16'h0030, 16'h0040);
    queue_frame(11'h030, 16'h9000, 16'h0000, 16'h0000);
    drain();

    // Receiver holds off while frames keep coming, so the input has to stall
    configure(ChassisThrRst, FeederThrRst, CountsTurnRst, GimbalIdRst, FrontIdRst,
              BackIdRst, PitchIdRst, FeederIdRst);
    burst_mode = 1'b1;
    @(posedge clk_i);
    rx_hold = 120;
    for (int k = 0; k < 40; k++) queue_random_frame();
    drain();
    burst_mode = 1'b0;

    // Random phases; the sender pauses half way until all feedback is in
    for (int ph = 0; ph < 5; ph++) begin
      random_config();
      burst_mode = (ph == 2);
      for (int k = 0; k < 45; k++) queue_random_frame();
      drain();
      for (int k = 0; k < 45; k++) queue_random_frame();
      drain();
    end
    burst_mode = 1'b0;

    // Short sweeps with a zero threshold and the largest counts per turn:
    // every frame after the first of a sweep steps the turn count, down for front and up for back
    configure(16'h0000, FeederThrRst, 16'hFFFF, GimbalIdRst, FrontIdRst, BackIdRst,
              PitchIdRst, FeederIdRst);
    burst_mode = 1'b1;
    for (int k = 1; k <= 18; k++) queue_frame(FrontIdRst, 16'(k * 1000), 16'(k), 16'h0000);
    for (int k = 0; k < 18; k++) queue_frame(BackIdRst, 16'(65535 - k * 1000), 16'h0000, 16'(k));
    drain();
    burst_mode = 1'b0;

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
